FILE: rtl/lghm_pkg.sv
package lghm_pkg;

  localparam int ADDR_W     = 48;
  localparam int GID_W      = 8;
  localparam int CFG_W      = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [1:0] {
    CMD_DEVICE = 2'd0,
    CMD_GROUP  = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ADV_NONE       = 2'd0,
    ADV_DISABLE    = 2'd1,
    ADV_CONSIDER   = 2'd2,
    ADV_INACTIVATE = 2'd3
  } adv_e;

  // Group event types
  localparam logic [1:0] STAT_SUCCESS      = 2'd0;
  localparam logic [1:0] STAT_CTX_MISS     = 2'd3;
  // Device event types that mean an invalid record
  localparam logic [1:0] STAT_INVALID_DB   = 2'd1;
  localparam logic [1:0] STAT_INVALID_CSIS = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_FAIL_LIMIT  = 1'b0;
  localparam logic REG_DISABLE_PCT = 1'b1;

  localparam logic [CFG_W-1:0] FAIL_LIMIT_RST  = 8'd3;
  localparam logic [CFG_W-1:0] DISABLE_PCT_RST = 8'd70;
  localparam logic [CFG_W-1:0] PERCENT_SCALE   = 8'd100;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] device_address;
    logic [GID_W-1:0]  group_num;
    logic              group_known;
    logic [1:0]        stat_type;
    logic              has_front_device;
  } in_t;

  typedef struct packed {
    logic              notify;
    logic              for_group;
    logic [ADDR_W-1:0] report_address;
    logic [GID_W-1:0]  report_group;
    logic [1:0]        recommendation;
    logic              status;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] fail_limit;
    logic [CFG_W-1:0] disable_percent;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_MUL,
    S_COMMIT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic mul;
    logic commit;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/link_group_health_monitor_unit.sv
// An accepted transaction passes through the scan, drain, update, multiply, commit and result
// states; no new transaction is taken until its result is pushed. The key scan reads one entry
// of each table RAM per cycle, over max(GROUP_ENTRIES, DEVICE_ENTRIES) entries.
// A finished result waits in the output register while the next transaction is taken.
// Reset clears all occupancy bits and loads fail_limit = 3, disable_percent = 70;
// table RAM contents are not cleared and no clearing pass runs.
module link_group_health_monitor_unit
  import lghm_pkg::*;
#(
  parameter int GROUP_ENTRIES  = 8,
  parameter int DEVICE_ENTRIES = 16,
  parameter int COUNT_BITS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  lghm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  lghm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  lghm_dp #(
    .GROUP_ENTRIES  (GROUP_ENTRIES),
    .DEVICE_ENTRIES (DEVICE_ENTRIES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

FILE: rtl/lghm_ram.sv
module lghm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lghm_regs.sv
module lghm_regs
  import lghm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Byte offset bits are ignored: register index sits in paddr[2]
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        REG_FAIL_LIMIT:  cfg_d.fail_limit      = pwdata_i[CFG_W-1:0];
        REG_DISABLE_PCT: cfg_d.disable_percent = pwdata_i[CFG_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit      <= FAIL_LIMIT_RST;
      cfg_q.disable_percent <= DISABLE_PCT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_FAIL_LIMIT:  prdata_o = APB_DATA_W'(cfg_q.fail_limit);
      REG_DISABLE_PCT: prdata_o = APB_DATA_W'(cfg_q.disable_percent);
      default:         prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

FILE: rtl/lghm_ctrl.sv
module lghm_ctrl
  import lghm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_MUL;
      S_MUL:    state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESULT;
      S_RESULT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_DRAIN:  cmd_o        = '0;
      S_UPDATE: cmd_o.update = 1'b1;
      S_MUL:    cmd_o.mul    = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_RESULT: cmd_o.push   = status_i.out_free;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SCAN))
    else $error("accepted transaction did not start a table scan");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !status_i.scan_last) |=> (state_q == S_SCAN))
    else $error("table scan left before the last entry");
`endif

endmodule

FILE: rtl/lghm_dp.sv
module lghm_dp
  import lghm_pkg::*;
#(
  parameter int GROUP_ENTRIES  = 8,
  parameter int DEVICE_ENTRIES = 16,
  parameter int COUNT_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_data_i,
  input  cfg_t       cfg_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_t       out_data_o,
  input  logic       out_stall_i
);

  localparam int SCAN_N = (GROUP_ENTRIES > DEVICE_ENTRIES) ? GROUP_ENTRIES : DEVICE_ENTRIES;
  localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int GI_W   = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
  localparam int DI_W   = (DEVICE_ENTRIES > 1) ? $clog2(DEVICE_ENTRIES) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int GW     = GID_W + 3 * CB + 2;
  localparam int DW     = ADDR_W + 2;
  localparam int CMP_W  = (CB > CFG_W) ? CB : CFG_W;
  localparam int PROD_W = CB + CFG_W;
  // Group word layout: key, success, failure, context miss, advice
  localparam int C_LO   = 2;
  localparam int F_LO   = CB + 2;
  localparam int S_LO   = 2 * CB + 2;
  localparam int K_LO   = 3 * CB + 2;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (&v) ? v : v + CB'(1);
  endfunction

  in_t                 item_q;
  logic [IDX_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;

  logic [GROUP_ENTRIES-1:0]  g_used_q;
  logic [DEVICE_ENTRIES-1:0] d_used_q;

  logic            g_hit_q, g_free_q, d_hit_q, d_free_q;
  logic [GI_W-1:0] g_hit_idx_q, g_free_idx_q;
  logic [DI_W-1:0] d_hit_idx_q, d_free_idx_q;
  logic [GW-1:0]   g_word_q;
  logic [1:0]      d_adv_q;

  logic [CB-1:0]     s_q, f_q, c_q;
  logic [1:0]        g_old_q, d_old_q;
  logic [PROD_W-1:0] prod_f_q, prod_s_q;
  logic              f_lim_q, c_lim_q;

  out_t res_q, res_d;
  out_t out_q;
  logic out_valid_q;
  logic out_free;

  logic [GW-1:0] g_rdata, g_wdata;
  logic [DW-1:0] d_rdata, d_wdata;
  logic          g_we, d_we;
  logic [GI_W-1:0] g_sel_idx;
  logic [DI_W-1:0] d_sel_idx;
  logic            g_full, d_full;

  // ---------------------------------------------------------------- scan
  logic g_in_range, d_in_range, g_used_rd, d_used_rd;
  logic g_key_hit, d_key_hit, g_free_rd, d_free_rd;

  assign g_in_range = {{(32-IDX_W){1'b0}}, rd_idx_q} < 32'(GROUP_ENTRIES);
  assign d_in_range = {{(32-IDX_W){1'b0}}, rd_idx_q} < 32'(DEVICE_ENTRIES);
  assign g_used_rd  = g_in_range ? g_used_q[rd_idx_q[GI_W-1:0]] : 1'b0;
  assign d_used_rd  = d_in_range ? d_used_q[rd_idx_q[DI_W-1:0]] : 1'b0;
  assign g_key_hit  = g_used_rd && (g_rdata[GW-1:K_LO] == item_q.group_num);
  assign d_key_hit  = d_used_rd && (d_rdata[DW-1:2] == item_q.device_address);
  assign g_free_rd  = g_in_range && !g_used_rd;
  assign d_free_rd  = d_in_range && !d_used_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (rd_vld_q && g_key_hit) begin
      g_hit_idx_q <= rd_idx_q[GI_W-1:0];
      g_word_q    <= g_rdata;
    end
    if (rd_vld_q && g_free_rd && !g_free_q) begin
      g_free_idx_q <= rd_idx_q[GI_W-1:0];
    end
    if (rd_vld_q && d_key_hit) begin
      d_hit_idx_q <= rd_idx_q[DI_W-1:0];
      d_adv_q     <= d_rdata[1:0];
    end
    if (rd_vld_q && d_free_rd && !d_free_q) begin
      d_free_idx_q <= rd_idx_q[DI_W-1:0];
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      g_hit_q  <= 1'b0;
      g_free_q <= 1'b0;
      d_hit_q  <= 1'b0;
      d_free_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        idx_q    <= '0;
        g_hit_q  <= 1'b0;
        g_free_q <= 1'b0;
        d_hit_q  <= 1'b0;
        d_free_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (rd_vld_q && g_key_hit) begin
          g_hit_q <= 1'b1;
        end
        if (rd_vld_q && g_free_rd) begin
          g_free_q <= 1'b1;
        end
        if (rd_vld_q && d_key_hit) begin
          d_hit_q <= 1'b1;
        end
        if (rd_vld_q && d_free_rd) begin
          d_free_q <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------- update
  logic [CB-1:0] s_base, f_base, c_base, s_upd, f_upd, c_upd;

  assign g_sel_idx = g_hit_q ? g_hit_idx_q : g_free_idx_q;
  assign d_sel_idx = d_hit_q ? d_hit_idx_q : d_free_idx_q;
  assign g_full    = !g_hit_q && !g_free_q;
  assign d_full    = !d_hit_q && !d_free_q;

  // A fresh entry starts with zero counters and no advice
  assign s_base = g_hit_q ? g_word_q[S_LO +: CB] : '0;
  assign f_base = g_hit_q ? g_word_q[F_LO +: CB] : '0;
  assign c_base = g_hit_q ? g_word_q[C_LO +: CB] : '0;

  always_comb begin
    s_upd = s_base;
    f_upd = f_base;
    c_upd = c_base;
    if (item_q.has_front_device) begin
      case (item_q.stat_type)
        STAT_SUCCESS:  s_upd = sat_inc(s_base);
        STAT_CTX_MISS: c_upd = sat_inc(c_base);
        default:       f_upd = sat_inc(f_base);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      s_q     <= s_upd;
      f_q     <= f_upd;
      c_q     <= c_upd;
      g_old_q <= g_hit_q ? g_word_q[1:0] : ADV_NONE;
      d_old_q <= d_hit_q ? d_adv_q : ADV_NONE;
    end
    // failures/successes >= percent/100, cross-multiplied
    if (cmd_i.mul) begin
      prod_f_q <= PROD_W'(f_q) * PROD_W'(PERCENT_SCALE);
      prod_s_q <= PROD_W'(s_q) * PROD_W'(cfg_i.disable_percent);
      f_lim_q  <= CMP_W'(f_q) >= CMP_W'(cfg_i.fail_limit);
      c_lim_q  <= CMP_W'(c_q) >= CMP_W'(cfg_i.fail_limit);
    end
  end

  // -------------------------------------------------------------- commit
  logic       skip_rules;
  logic [1:0] g_act, g_new_adv, d_act;
  logic [CB-1:0] c_new;

  assign skip_rules = !item_q.has_front_device ||
                      ((item_q.stat_type == STAT_SUCCESS) && (g_old_q == ADV_NONE));

  always_comb begin
    g_act = ADV_NONE;
    if (s_q == '0) begin
      if (f_lim_q) begin
        g_act = ADV_DISABLE;
      end else if (c_lim_q) begin
        g_act = ADV_INACTIVATE;
      end
    end else begin
      if (prod_f_q >= prod_s_q) begin
        g_act = ADV_CONSIDER;
      end else if (c_lim_q) begin
        g_act = ADV_INACTIVATE;
      end
    end
  end

  assign g_new_adv = skip_rules ? g_old_q : g_act;
  assign c_new     = (!skip_rules && (g_act == ADV_INACTIVATE)) ? '0 : c_q;
  assign d_act     = ((item_q.stat_type == STAT_INVALID_DB) ||
                      (item_q.stat_type == STAT_INVALID_CSIS)) ? ADV_DISABLE : ADV_NONE;

  assign g_we    = cmd_i.commit && (item_q.cmd == CMD_GROUP) && !g_full;
  assign d_we    = cmd_i.commit && (item_q.cmd == CMD_DEVICE) && !d_full;
  assign g_wdata = {item_q.group_num, s_q, f_q, c_new, g_new_adv};
  assign d_wdata = {item_q.device_address, d_act};

  always_comb begin
    res_d = '0;
    case (item_q.cmd)
      CMD_DEVICE: begin
        if (d_full) begin
          res_d.status = 1'b1;
        end else if (d_act != d_old_q) begin
          res_d.notify         = 1'b1;
          res_d.report_address = item_q.device_address;
          res_d.recommendation = d_act;
        end
      end
      CMD_GROUP: begin
        if (g_full) begin
          res_d.status = 1'b1;
        end else if (g_new_adv != g_old_q) begin
          res_d.notify         = 1'b1;
          res_d.for_group      = 1'b1;
          res_d.report_group   = item_q.group_num;
          res_d.recommendation = g_new_adv;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_used_q <= '0;
      d_used_q <= '0;
    end else if (cmd_i.commit) begin
      if (g_we) begin
        g_used_q[g_sel_idx] <= 1'b1;
      end
      if (d_we) begin
        d_used_q[d_sel_idx] <= 1'b1;
      end
      if (item_q.cmd == CMD_REMOVE) begin
        if (d_hit_q) begin
          d_used_q[d_hit_idx_q] <= 1'b0;
        end
        if (item_q.group_known && g_hit_q) begin
          g_used_q[g_hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  lghm_ram #(
    .WIDTH (GW),
    .DEPTH (GROUP_ENTRIES)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_sel_idx),
    .wdata_i (g_wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (idx_q[GI_W-1:0]),
    .rdata_o (g_rdata)
  );

  lghm_ram #(
    .WIDTH (DW),
    .DEPTH (DEVICE_ENTRIES)
  ) u_device_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_sel_idx),
    .wdata_i (d_wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (idx_q[DI_W-1:0]),
    .rdata_o (d_rdata)
  );

  // -------------------------------------------------------------- output
  assign out_free = !out_valid_q || !out_stall_i;
  assign status_o = '{scan_last: (idx_q == IDX_W'(SCAN_N - 1)), out_free: out_free};

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_used_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> (g_used_q == $past(g_used_q)) && (d_used_q == $past(d_used_q)))
    else $error("table occupancy changed outside commit");

  a_full_never_notifies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_q.status && out_q.notify))
    else $error("dropped transaction reported a recommendation");

  a_push_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule
